// ===== src/mtep_pkg.sv =====
// Shared constants and codes for the MIDI track event parser.
// No dependencies; compile first.
package mtep_pkg;

   localparam int DEF_TICK_WIDTH   = 48;
   localparam int DEF_LENGTH_WIDTH = 16;

   localparam int EVENT_TICK_W = 48;
   localparam int BODY_LEN_W   = 16;

   localparam logic [7:0] DATA_MASK   = 8'h7F;
   localparam logic [7:0] STATUS_BIT  = 8'h80;
   localparam logic [7:0] META_STATUS = 8'hFF;
   localparam logic [7:0] SYSTEM_BASE = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;
   localparam logic [7:0] CLASS_MASK  = 8'hE0;
   localparam logic [7:0] ONE_BYTE_CLASS = 8'hC0;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_NO_STATUS  = 2'd1;
   localparam logic [1:0] ERR_BAD_DATA   = 2'd2;
   localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

endpackage

// ===== src/mtep_req_if.sv =====
// Input channel of the MIDI track event parser: one chunk byte per beat.
// Depends on mtep_pkg.
interface mtep_req_if import mtep_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_in_chunk;

   modport source (output valid, output byte_in, output last_in_chunk, input ready);
   modport sink   (input valid, input byte_in, input last_in_chunk, output ready);
endinterface

// ===== src/mtep_rsp_if.sv =====
// Result channel of the MIDI track event parser: one event or error per beat.
// Depends on mtep_pkg.
interface mtep_rsp_if import mtep_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [EVENT_TICK_W-1:0] event_tick;
   logic [7:0]              status_out;
   logic [7:0]              first_data;
   logic [7:0]              second_data;
   logic [BODY_LEN_W-1:0]   body_length;
   logic [1:0]              error_code;

   modport source (output valid, output event_tick, output status_out, output first_data,
                   output second_data, output body_length, output error_code,
                   input ready);
   modport sink   (input valid, input event_tick, input status_out, input first_data,
                   input second_data, input body_length, input error_code,
                   output ready);
endinterface

// ===== src/midi_track_event_parser.sv =====
// Top level of the MIDI track event parser: delta/status/body decoding.
// Depends on mtep_pkg, mtep_req_if and mtep_rsp_if.
//
//   channel   dir  beat                           handshake
//   req_bus   in   byte_in, last_in_chunk         valid/ready
//   rsp_bus   out  tick, status, data, len, err   valid/ready
//
// One byte per cycle while req_bus.ready is high; parse state and any result are
// registered at the accepting edge, so a result is offered in the cycle after its byte.
// req_bus.ready is low only while a result sits in the output register and
// rsp_bus.ready is low.
// Reset is synchronous and clears all parse state, including running status.
module midi_track_event_parser import mtep_pkg::*; #(
   parameter int TICK_WIDTH   = DEF_TICK_WIDTH,
   parameter int LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
   input  logic   clock,
   input  logic   reset,
   mtep_req_if.sink   req_bus,
   mtep_rsp_if.source rsp_bus
);

   typedef enum logic [1:0] {PH_DELTA, PH_STATUS, PH_BODY} phase_type;

   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

   phase_type               phase_ff, phase_in;
   logic [31:0]             delta_ff, delta_in;
   logic [TICK_WIDTH-1:0]   tick_ff, tick_in;
   logic [7:0]              run_ff, run_in;
   logic [7:0]              cur_ff, cur_in;
   logic [LENGTH_WIDTH-1:0] cnt_ff, cnt_in;
   logic [LENGTH_WIDTH-1:0] exp_ff, exp_in;
   logic [7:0]              first_ff, first_in;
   logic [7:0]              second_ff, second_in;
   logic                    skip_ff, skip_in;

   logic                    out_valid_ff;
   logic [EVENT_TICK_W-1:0] out_tick_ff;
   logic [TICK_WIDTH-1:0]   out_tick_in;
   logic [7:0]              out_status_ff, out_status_in;
   logic [7:0]              out_first_ff, out_first_in;
   logic [7:0]              out_second_ff, out_second_in;
   logic [BODY_LEN_W-1:0]   out_len_ff;
   logic [1:0]              out_err_ff, out_err_in;
   logic [LENGTH_WIDTH-1:0] out_cnt_in;

   logic        accept;
   logic        emit;
   logic [63:0] tick_wide;
   logic [31:0] len_wide;

   assign req_bus.ready = !out_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      logic [7:0]              b;
      logic                    last;
      logic [31:0]             acc;
      logic                    in_body;
      logic [7:0]              st;
      logic [LENGTH_WIDTH-1:0] cnt;
      logic [LENGTH_WIDTH-1:0] expct;
      logic [7:0]              hf;
      logic [7:0]              hs;
      logic                    done;
      logic                    fail;
      logic                    is_sys;

      b       = req_bus.byte_in;
      last    = req_bus.last_in_chunk;
      acc     = '0;
      in_body = 1'b0;
      st      = cur_ff;
      cnt     = cnt_ff;
      expct   = exp_ff;
      hf      = first_ff;
      hs      = second_ff;
      done    = 1'b0;
      fail    = 1'b0;
      is_sys  = 1'b0;

      phase_in  = phase_ff;
      delta_in  = delta_ff;
      tick_in   = tick_ff;
      run_in    = run_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      exp_in    = exp_ff;
      first_in  = first_ff;
      second_in = second_ff;
      skip_in   = skip_ff;

      emit          = 1'b0;
      out_status_in = '0;
      out_first_in  = '0;
      out_second_in = '0;
      out_cnt_in    = '0;
      out_err_in    = ERR_NONE;

      if (!skip_ff) begin
         case (phase_ff)
            PH_DELTA: begin
               acc = {delta_ff[24:0], b[6:0]};
               delta_in = acc;
               if ((b & STATUS_BIT) == 8'h00) begin
                  tick_in  = tick_ff + TICK_WIDTH'(acc);
                  delta_in = '0;
                  phase_in = PH_STATUS;
               end
               if (last) begin
                  fail       = 1'b1;
                  out_err_in = ERR_TRUNCATED;
               end
            end
            PH_STATUS: begin
               if ((b & STATUS_BIT) != 8'h00) begin
                  cur_in   = b;
                  run_in   = b;
                  phase_in = PH_BODY;
                  cnt_in   = '0;
                  exp_in   = ((b & CLASS_MASK) == ONE_BYTE_CLASS) ?
                             LENGTH_WIDTH'(1) : LENGTH_WIDTH'(2);
                  if (last) begin
                     fail          = 1'b1;
                     out_err_in    = ERR_TRUNCATED;
                     out_status_in = b;
                  end
               end else if (run_ff == 8'h00) begin
                  fail       = 1'b1;
                  out_err_in = ERR_NO_STATUS;
               end else begin
                  in_body = 1'b1;
                  st      = run_ff;
                  cnt     = '0;
                  expct   = ((run_ff & CLASS_MASK) == ONE_BYTE_CLASS) ?
                            LENGTH_WIDTH'(1) : LENGTH_WIDTH'(2);
               end
            end
            PH_BODY: in_body = 1'b1;
            default: in_body = 1'b0;
         endcase

         if (in_body) begin
            is_sys   = (st & SYSTEM_BASE) == SYSTEM_BASE;
            cur_in   = st;
            phase_in = PH_BODY;
            if (!is_sys && (b & STATUS_BIT) != 8'h00) begin
               fail          = 1'b1;
               out_err_in    = ERR_BAD_DATA;
               out_status_in = st;
            end else begin
               if (cnt == '0) hf = b;
               else if (cnt == LENGTH_WIDTH'(1)) hs = b;
               if (cnt < LEN_MAX) cnt = cnt + LENGTH_WIDTH'(1);
               if (st == META_STATUS) begin
                  if (cnt == LENGTH_WIDTH'(2)) expct = LENGTH_WIDTH'(hs) + LENGTH_WIDTH'(2);
                  done = (cnt >= LENGTH_WIDTH'(2)) && (cnt == expct);
               end else if (is_sys) begin
                  done = b == SYSEX_END;
               end else begin
                  done = cnt == expct;
               end
               cnt_in    = cnt;
               exp_in    = expct;
               first_in  = hf;
               second_in = hs;
               if (done) begin
                  emit          = 1'b1;
                  out_status_in = st;
                  out_first_in  = hf;
                  out_second_in = hs;
                  out_cnt_in    = cnt;
                  phase_in  = PH_DELTA;
                  delta_in  = '0;
                  cur_in    = '0;
                  cnt_in    = '0;
                  exp_in    = '0;
                  first_in  = '0;
                  second_in = '0;
               end else if (last) begin
                  fail          = 1'b1;
                  out_err_in    = ERR_TRUNCATED;
                  out_status_in = st;
               end
            end
         end

         if (fail) begin
            emit      = 1'b1;
            phase_in  = PH_DELTA;
            delta_in  = '0;
            cur_in    = '0;
            cnt_in    = '0;
            exp_in    = '0;
            first_in  = '0;
            second_in = '0;
            skip_in   = !last;
         end
      end

      out_tick_in = tick_in;

      if (last) begin
         phase_in  = PH_DELTA;
         delta_in  = '0;
         cur_in    = '0;
         cnt_in    = '0;
         exp_in    = '0;
         first_in  = '0;
         second_in = '0;
         tick_in   = '0;
         skip_in   = 1'b0;
      end
   end

   // tick reported is the value after this byte's delta is applied
   assign tick_wide = 64'(out_tick_in);
   assign len_wide  = 32'(out_cnt_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DELTA;
         delta_ff  <= '0;
         tick_ff   <= '0;
         run_ff    <= '0;
         cur_ff    <= '0;
         cnt_ff    <= '0;
         exp_ff    <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         skip_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            delta_ff  <= delta_in;
            tick_ff   <= tick_in;
            run_ff    <= run_in;
            cur_ff    <= cur_in;
            cnt_ff    <= cnt_in;
            exp_ff    <= exp_in;
            first_ff  <= first_in;
            second_ff <= second_in;
            skip_ff   <= skip_in;
         end
         if (accept && emit) out_valid_ff <= 1'b1;
         else if (rsp_bus.ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_tick_ff   <= tick_wide[EVENT_TICK_W-1:0];
         out_status_ff <= out_status_in;
         out_first_ff  <= out_first_in;
         out_second_ff <= out_second_in;
         out_len_ff    <= len_wide[BODY_LEN_W-1:0];
         out_err_ff    <= out_err_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.event_tick  = out_tick_ff;
   assign rsp_bus.status_out  = out_status_ff;
   assign rsp_bus.first_data  = out_first_ff;
   assign rsp_bus.second_data = out_second_ff;
   assign rsp_bus.body_length = out_len_ff;
   assign rsp_bus.error_code  = out_err_ff;

endmodule

// ===== src/mtep_checker.sv =====
// Port-level checks for the MIDI track event parser, bound to the top level.
// Depends on mtep_pkg and midi_track_event_parser.
module mtep_checker import mtep_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [EVENT_TICK_W-1:0] rsp_event_tick,
   input logic [7:0]              rsp_status_out,
   input logic [7:0]              rsp_first_data,
   input logic [7:0]              rsp_second_data,
   input logic [BODY_LEN_W-1:0]   rsp_body_length,
   input logic [1:0]              rsp_error_code
);

   logic unused_req_valid;
   assign unused_req_valid = req_valid;

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_tick) &&
      $stable(rsp_status_out) && $stable(rsp_body_length) && $stable(rsp_error_code))
      else $error("result beat changed while stalled");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while result register full");

   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |->
      rsp_first_data == 8'h00 && rsp_second_data == 8'h00 && rsp_body_length == '0)
      else $error("error beat carries body fields");

   a_no_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_NO_STATUS |-> rsp_status_out == 8'h00)
      else $error("missing-status error with a status");

   a_chan_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_NONE && rsp_status_out[7:4] != 4'hF |->
      rsp_status_out[7] && (rsp_body_length == 16'd1 || rsp_body_length == 16'd2))
      else $error("channel event with bad body length");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_event_tick  (rsp_bus.event_tick),
   .rsp_status_out  (rsp_bus.status_out),
   .rsp_first_data  (rsp_bus.first_data),
   .rsp_second_data (rsp_bus.second_data),
   .rsp_body_length (rsp_bus.body_length),
   .rsp_error_code  (rsp_bus.error_code)
);

// ===== dv/tb.sv =====
// Self-checking testbench for midi_track_event_parser: directed, long-run and random chunks.
// A local mirror of the parser predicts every result beat, which is checked field by field.
// Depends on mtep_pkg, mtep_req_if, mtep_rsp_if and the parser RTL.
module tb;
   import mtep_pkg::*;

   typedef enum logic [1:0] {PH_DELTA, PH_STATUS, PH_BODY} parse_phase_type;

   typedef struct packed {
      logic [EVENT_TICK_W-1:0] tick;
      logic [7:0]              status;
      logic [7:0]              first;
      logic [7:0]              second;
      logic [BODY_LEN_W-1:0]   length;
      logic [1:0]              code;
   } track_event_type;

   logic clock;
   logic reset;

   mtep_req_if req_bus ();
   mtep_rsp_if rsp_bus ();

   midi_track_event_parser DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // parser mirror
   parse_phase_type         mir_phase;
   logic [31:0]             mir_delta;
   logic [EVENT_TICK_W-1:0] mir_tick;
   logic [7:0]              mir_running;
   logic [7:0]              mir_status;
   logic [7:0]              mir_first;
   logic [7:0]              mir_second;
   logic [BODY_LEN_W-1:0]   mir_count;
   logic [BODY_LEN_W-1:0]   mir_body_len;
   bit                      mir_skip;

   track_event_type expected_events[$];
   logic [7:0]      chunk_bytes[$];
   logic [7:0]      gen_running;
   int              send_idle_pct;
   int              recv_idle_pct;
   int              hold_cycles;
   int              bytes_sent;
   int              events_checked;
   int              failures;
   int              code_count[4];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("%0t: timeout, %0d results outstanding", $time, expected_events.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic void append_byte(logic [7:0] b);
      chunk_bytes.insert(chunk_bytes.size(), b);
   endfunction

   function automatic void drop_event();
      mir_phase    = PH_DELTA;
      mir_delta    = '0;
      mir_status   = '0;
      mir_count    = '0;
      mir_body_len = '0;
      mir_first    = '0;
      mir_second   = '0;
   endfunction

   function automatic logic [BODY_LEN_W-1:0] channel_length(logic [7:0] st);
      return ((st & CLASS_MASK) == ONE_BYTE_CLASS) ? BODY_LEN_W'(1) : BODY_LEN_W'(2);
   endfunction

   function automatic track_event_type abort_event(logic [1:0] code, bit last);
      track_event_type ev;
      ev        = '0;
      ev.tick   = mir_tick;
      ev.status = (mir_phase == PH_BODY) ? mir_status : 8'h00;
      ev.code   = code;
      drop_event();
      if (!last) mir_skip = 1'b1;
      return ev;
   endfunction

   function automatic bit take_body_byte(logic [7:0] b, bit last, output track_event_type ev);
      bit done;
      ev = '0;
      if ((mir_status & SYSTEM_BASE) != SYSTEM_BASE && (b & STATUS_BIT) != 8'h00) begin
         ev = abort_event(ERR_BAD_DATA, last);
         return 1'b1;
      end
      if (mir_count == 0) mir_first = b;
      else if (mir_count == 1) mir_second = b;
      if (mir_count != {BODY_LEN_W{1'b1}}) mir_count++;
      if (mir_status == META_STATUS) begin
         if (mir_count == 2) mir_body_len = BODY_LEN_W'(mir_second) + BODY_LEN_W'(2);
         done = (mir_count >= 2) && (mir_count == mir_body_len);
      end else if ((mir_status & SYSTEM_BASE) == SYSTEM_BASE) begin
         done = (b == SYSEX_END);
      end else begin
         done = (mir_count == mir_body_len);
      end
      if (done) begin
         ev.tick   = mir_tick;
         ev.status = mir_status;
         ev.first  = mir_first;
         ev.second = mir_second;
         ev.length = mir_count;
         ev.code   = ERR_NONE;
         drop_event();
         return 1'b1;
      end
      if (last) begin
         ev = abort_event(ERR_TRUNCATED, last);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit parse_track_byte(logic [7:0] b, bit last, output track_event_type ev);
      bit got;
      got = 1'b0;
      ev  = '0;
      if (!mir_skip) begin
         case (mir_phase)
            PH_DELTA: begin
               mir_delta = (mir_delta << 7) + {25'd0, b[6:0]};
               if ((b & STATUS_BIT) == 8'h00) begin
                  mir_tick  = mir_tick + {{(EVENT_TICK_W-32){1'b0}}, mir_delta};
                  mir_delta = '0;
                  mir_phase = PH_STATUS;
               end
               if (last) begin
                  ev  = abort_event(ERR_TRUNCATED, last);
                  got = 1'b1;
               end
            end
            PH_STATUS: begin
               if ((b & STATUS_BIT) != 8'h00) begin
                  mir_status   = b;
                  mir_running  = b;
                  mir_phase    = PH_BODY;
                  mir_count    = '0;
                  mir_body_len = channel_length(b);
                  if (last) begin
                     ev  = abort_event(ERR_TRUNCATED, last);
                     got = 1'b1;
                  end
               end else if (mir_running == 8'h00) begin
                  ev  = abort_event(ERR_NO_STATUS, last);
                  got = 1'b1;
               end else begin
                  mir_status   = mir_running;
                  mir_phase    = PH_BODY;
                  mir_count    = '0;
                  mir_body_len = channel_length(mir_running);
                  got          = take_body_byte(b, last, ev);
               end
            end
            default: got = take_body_byte(b, last, ev);
         endcase
      end
      if (last) begin
         drop_event();
         mir_tick = '0;
         mir_skip = 1'b0;
      end
      return got;
   endfunction

   function automatic void check_field(string what, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
         failures++;
         if (failures <= 40)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin : rsp_monitor
      track_event_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_events.size() == 0) begin
            failures++;
            if (failures <= 40)
               $display("%0t: unexpected beat, actual tick %0h status %0h code %0d",
                        $time, rsp_bus.event_tick, rsp_bus.status_out, rsp_bus.error_code);
         end else begin
            want = expected_events.pop_front();
            check_field("event_tick", 48'(want.tick), 48'(rsp_bus.event_tick));
            check_field("status_out", 48'(want.status), 48'(rsp_bus.status_out));
            check_field("first_data", 48'(want.first), 48'(rsp_bus.first_data));
            check_field("second_data", 48'(want.second), 48'(rsp_bus.second_data));
            check_field("body_length", 48'(want.length), 48'(rsp_bus.body_length));
            check_field("error_code", 48'(want.code), 48'(rsp_bus.error_code));
            code_count[want.code]++;
            events_checked++;
         end
      end
      if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit last);
      track_event_type ev;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.byte_in       <= b;
      req_bus.last_in_chunk <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (parse_track_byte(b, last, ev)) expected_events.insert(expected_events.size(), ev);
      bytes_sent++;
   endtask

   task automatic send_chunk();
      int i;
      for (i = 0; i < chunk_bytes.size(); i++)
         send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
      chunk_bytes.delete();
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_events.size() != 0);
   endtask

   function automatic void add_delta(int nbytes);
      int k;
      for (k = nbytes - 1; k >= 0; k--)
         append_byte(8'($urandom_range(127)) | ((k != 0) ? STATUS_BIT : 8'h00));
   endfunction

   function automatic void add_random_event();
      int         pick;
      int         n;
      int         k;
      logic [7:0] st;
      logic [7:0] b;
      bit         explicit_status;
      pick = $urandom_range(99);
      add_delta(($urandom_range(9) < 7) ? 1 : $urandom_range(5, 2));
      explicit_status = 1'b1;
      if (pick < 20 && gen_running != 8'h00) begin
         st              = gen_running;
         explicit_status = 1'b0;
      end else if (pick < 60) begin
         st = 8'($urandom_range(8'hEF, 8'h80));
      end else if (pick < 80) begin
         st = META_STATUS;
      end else begin
         st = 8'($urandom_range(8'hFE, 8'hF0));
      end
      if (explicit_status) append_byte(st);
      gen_running = st;
      if (st == META_STATUS) begin
         append_byte(8'($urandom_range(explicit_status ? 255 : 127)));
         n = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(4);
         append_byte(8'(n));
         repeat (n) append_byte(8'($urandom_range(255)));
      end else if ((st & SYSTEM_BASE) == SYSTEM_BASE) begin
         n = $urandom_range(5, explicit_status ? 0 : 1);
         for (k = 0; k < n; k++) begin
            b = (k == 0 && !explicit_status) ? 8'($urandom_range(127)) : 8'($urandom_range(255));
            if (b == SYSEX_END) b = 8'h00;
            append_byte(b);
         end
         append_byte(SYSEX_END);
      end else begin
         n = ((st & CLASS_MASK) == ONE_BYTE_CLASS) ? 1 : 2;
         for (k = 0; k < n; k++) begin
            b = 8'($urandom_range(127));
            if ((k > 0 || explicit_status) && $urandom_range(99) < 3) b = b | STATUS_BIT;
            append_byte(b);
         end
      end
   endfunction

   task automatic run_random_chunks(input int target);
      int start;
      int pick;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         chunk_bytes.delete();
         gen_running = mir_running;
         pick        = $urandom_range(99);
         if (pick < 6) begin
            repeat ($urandom_range(8, 1)) append_byte(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(6, 1)) add_random_event();
            if (pick < 20) chunk_bytes = chunk_bytes[0:$urandom_range(chunk_bytes.size() - 1)];
         end
         send_chunk();
      end
   endtask

   // only possible before any status byte, as running status survives everything but reset
   task automatic test_missing_status();
      chunk_bytes = {8'h00, 8'h40, 8'h12, 8'h34};
      send_chunk();
      chunk_bytes = {8'h00, 8'h55};
      send_chunk();
      chunk_bytes = {8'h81};
      send_chunk();
      chunk_bytes = {8'h00};
      send_chunk();
      chunk_bytes = {8'h00, 8'h90};
      send_chunk();
   endtask

   task automatic test_channel_events();
      chunk_bytes = {8'h00, 8'h90, 8'h3C, 8'h7F, 8'h83, 8'h60, 8'hC5, 8'h12, 8'h00, 8'h40,
                     8'h00, 8'hEF, 8'h00, 8'h7F, 8'h00, 8'h80, 8'h7F, 8'h00};
      send_chunk();
   endtask

   task automatic test_meta_and_system();
      chunk_bytes = {8'h00, 8'hFF, 8'h2F, 8'h00, 8'h00, 8'hFF, 8'h03, 8'h02, 8'h41, 8'h42,
                     8'h00, 8'h05, 8'h00, 8'h00, 8'hF0, 8'h7E, 8'h7F, 8'hF7,
                     8'h00, 8'h12, 8'hF7, 8'h00, 8'hF7, 8'hF7, 8'h00, 8'hFE, 8'hF7};
      send_chunk();
   endtask

   task automatic test_bad_data();
      chunk_bytes = {8'h00, 8'h90, 8'h3C, 8'h90, 8'h11, 8'h22};
      send_chunk();
      chunk_bytes = {8'h00, 8'hB0, 8'h07, 8'h80};
      send_chunk();
      chunk_bytes = {8'h00, 8'hC0, 8'hFF};
      send_chunk();
   endtask

   task automatic test_truncation();
      chunk_bytes = {8'h00, 8'h90, 8'h3C};
      send_chunk();
      chunk_bytes = {8'h00, 8'hFF, 8'h01, 8'h03, 8'h41};
      send_chunk();
      chunk_bytes = {8'h00, 8'hF0, 8'h01};
      send_chunk();
      chunk_bytes = {8'h00, 8'h3C};
      send_chunk();
   endtask

   task automatic test_delta_wrap();
      chunk_bytes = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hC0, 8'h05,
                     8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h06};
      send_chunk();
   endtask

   // receiver held off long enough that the output register fills and req ready drops
   task automatic test_backpressure();
      int i;
      hold_cycles = 300;
      for (i = 0; i < 30; i++) begin
         append_byte(8'h00);
         append_byte(8'h90 | 8'(i & 15));
         append_byte(8'(i));
         append_byte(8'h40);
      end
      send_chunk();
      wait_for_drain();
   endtask

   task automatic test_long_sysex();
      int         i;
      logic [7:0] b;
      send_byte(8'h00, 1'b0);
      send_byte(SYSTEM_BASE, 1'b0);
      for (i = 0; i < 100; i++) begin
         b = 8'($urandom_range(255));
         if (b == SYSEX_END) b = 8'h00;
         send_byte(b, 1'b0);
      end
      send_byte(SYSEX_END, 1'b1);
   endtask

   // maximum delta on consecutive events; tick runs well past 32 bits
   task automatic test_max_deltas();
      int i;
      send_byte(8'h00, 1'b0);
      send_byte(8'hC0, 1'b0);
      send_byte(8'h00, 1'b0);
      for (i = 0; i < 20; i++) begin
         send_byte(8'h8F, 1'b0);
         send_byte(8'hFF, 1'b0);
         send_byte(8'hFF, 1'b0);
         send_byte(8'hFF, 1'b0);
         send_byte(8'h7F, 1'b0);
         send_byte(8'(i & 127), i == 19);
      end
   endtask

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.byte_in       = 8'h00;
      req_bus.last_in_chunk = 1'b0;
      hold_cycles           = 0;
      bytes_sent            = 0;
      events_checked        = 0;
      failures              = 0;
      gen_running           = 8'h00;
      drop_event();
      mir_tick      = '0;
      mir_running   = 8'h00;
      mir_skip      = 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 82;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_missing_status();
      test_channel_events();
      test_meta_and_system();
      test_bad_data();
      test_truncation();
      test_delta_wrap();
      test_backpressure();
      run_random_chunks(300);

      send_idle_pct = 82;
      recv_idle_pct = 23;
      run_random_chunks(300);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_long_sysex();
      test_max_deltas();
      run_random_chunks(300);

      wait_for_drain();
      repeat (20) @(posedge clock);

      $display("%0d bytes, %0d beats: %0d ok, %0d no status, %0d bad data, %0d cut short",
               bytes_sent, events_checked, code_count[0], code_count[1], code_count[2],
               code_count[3]);
      $display("covered running status across chunks, delta wrap, long sysex, output stalls");
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
